FILE: rtl/int4_group_dequantizer_assert.svh
`ifndef INT4_GROUP_DEQUANTIZER_ASSERT_SVH
`define INT4_GROUP_DEQUANTIZER_ASSERT_SVH
// Assertion helpers shared by the checker.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("reset check failed");
`endif

FILE: rtl/i4dq_pkg.sv
`timescale 1ns / 1ps
package i4dq_pkg;
  localparam int COLUMNS_DEF = 1024;
  localparam int NIBBLES = 16;
  localparam int SLOT_W = 10;

  typedef enum logic [1:0] {
    CMD_ZERO  = 2'd0,
    CMD_SCALE = 2'd1,
    CMD_WEIGHT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // A scale load carries its half value in the low bits of wword.
  typedef struct packed {
    logic              scale_ld;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       zword;
    logic [63:0]       wword;
  } job_t;

  // Float32 to half, round to nearest even.
  function automatic logic [15:0] f32_to_half(input logic [31:0] b);
    logic        s;
    logic [7:0]  e;
    logic [22:0] f;
    logic [23:0] m;
    logic [47:0] sh;
    logic [10:0] q;
    logic        g, st;
    logic [11:0] qr;
    int          he;
    int          amt;
    logic [15:0] r;
    s = b[31];
    e = b[30:23];
    f = b[22:0];
    r = 16'd0;
    if (e == 8'hFF) begin
      if (f == 23'd0) r = {s, 15'h7C00};
      else r = {s, 15'h7E00} | {6'd0, f[22:13]};
    end else if (e == 8'd0) begin
      r = {s, 15'd0};
    end else begin
      m = {1'b1, f};
      he = int'(e) - 112;
      if (he >= 31) begin
        r = {s, 15'h7C00};
      end else begin
        if (he >= 1) amt = 13;
        else amt = 14 - he;
        if (amt > 30) begin
          r = {s, 15'd0};
        end else begin
          sh = {m, 24'd0} >> amt;
          q = sh[34:24];
          g = sh[23];
          st = |sh[22:0];
          qr = {1'b0, q} + {11'd0, g & (st | q[0])};
          if (he >= 1) begin
            if (qr[11]) begin
              if (he + 1 >= 31) r = {s, 15'h7C00};
              else r = {s, 5'(he + 1), 10'd0};
            end else if (he >= 31) begin
              r = {s, 15'h7C00};
            end else begin
              r = {s, 5'(he), qr[9:0]};
            end
          end else begin
            r = {s, qr[10] ? 5'd1 : 5'd0, qr[9:0]};
          end
        end
      end
    end
    return r;
  endfunction

  // Exact widening of half to float32; the leading-one search is ten bits.
  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic [4:0] e;
    logic [9:0] f;
    logic [7:0] ee;
    logic [10:0] ff;
    logic [31:0] r;
    logic        found;
    e = h[14:10];
    f = h[9:0];
    ee = 8'd0;
    ff = 11'd0;
    found = 1'b0;
    if (e == 5'h1F) r = {h[15], 8'hFF, f, 13'd0};
    else if (e != 5'd0) r = {h[15], 8'(e) + 8'd112, f, 13'd0};
    else if (f == 10'd0) r = {h[15], 31'd0};
    else begin
      for (int i = 9; i >= 0; i--) begin
        if (!found && f[i]) begin
          found = 1'b1;
          ee = 8'(103 + i);
          ff = 11'({1'b0, f} << (10 - i));
        end
      end
      r = {h[15], ee, ff[9:0], 13'd0};
    end
    return r;
  endfunction
endpackage

FILE: rtl/int4_group_dequantizer.sv
`timescale 1ns / 1ps
// Channel   tuser      tdata (low bit first)                          tlast
// s_axis    cmd[1:0]   slot[9:0] payload[73:10], zero-filled to 80    -
// m_axis    -          value[31:0] column[41:32], zero-filled to 48   last
// Load items are accepted one a cycle unless a full job queue holds the front
// stage; a scale load passes the queue to the scale store, so it lands in order
// with earlier weight items. A weight item produces sixteen results, one a cycle
// unless the output stalls; the back part's nibble sequencer holds it until all
// sixteen nibbles are issued. Results pass the front stage, job queue, stages A
// and B and the output register. Reset is synchronous; stores hold nothing until
// written. Either side may stall; a two-entry job queue parts front from back.
module int4_group_dequantizer
  import i4dq_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // cmd
  input  logic [79:0] s_axis_tdata,  // slot, payload
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // value, column
  output logic        m_axis_tlast
);
  logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  job_t q_in_job, q_out_job;
  logic [31:0] value;
  logic [9:0] column;

  i4dq_front #(.COLUMNS(COLUMNS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cmd(s_axis_tuser), .slot(s_axis_tdata[9:0]), .payload(s_axis_tdata[73:10]),
    .q_ready(q_in_ready), .q_valid(q_in_valid), .q_job(q_in_job)
  );

  i4dq_queue u_queue (
    .clk, .rst,
    .wr_valid(q_in_valid), .wr_ready(q_in_ready), .wr_job(q_in_job),
    .rd_valid(q_out_valid), .rd_ready(q_out_ready), .rd_job(q_out_job)
  );

  i4dq_back #(.COLUMNS(COLUMNS)) u_back (
    .clk, .rst,
    .j_valid(q_out_valid), .j_ready(q_out_ready), .j_job(q_out_job),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .value, .column, .last(m_axis_tlast)
  );
  assign m_axis_tdata = {6'd0, column, value};
endmodule

FILE: rtl/i4dq_front.sv
`timescale 1ns / 1ps
module i4dq_front
  import i4dq_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [9:0]  slot,
  input  logic [63:0] payload,
  input  logic        q_ready,
  output logic        q_valid,
  output job_t        q_job
);
  localparam int CHUNKS = COLUMNS / NIBBLES;
  localparam int CW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  logic [63:0] zero_mem [CHUNKS];
  logic        st_valid;
  logic        st_sc;
  logic [9:0]  st_slot;
  logic [63:0] st_z;
  logic [63:0] st_w;
  logic        acc;
  logic        is_w;
  logic        is_sc;

  // A weight item's zero word is read from the zero store into a register before it enters the queue.
  // Scale loads travel through the queue too, so they reach the scale store in
  // order with the weight items ahead of them.
  assign in_ready = !st_valid || q_ready;
  assign acc = in_valid && in_ready;
  assign is_w = (cmd_t'(cmd) == CMD_WEIGHT) && (32'(slot) < CHUNKS);
  assign is_sc = (cmd_t'(cmd) == CMD_SCALE) && (32'(slot) < COLUMNS);
  assign q_valid = st_valid;
  assign q_job.scale_ld = st_sc;
  assign q_job.slot = st_slot;
  assign q_job.zword = st_z;
  assign q_job.wword = st_w;

  always_ff @(posedge clk) begin
    if (acc && cmd_t'(cmd) == CMD_ZERO && 32'(slot) < CHUNKS)
      zero_mem[slot[CW-1:0]] <= payload;
    if (acc) begin
      st_z <= zero_mem[slot[CW-1:0]];
      st_slot <= slot;
      st_sc <= is_sc;
      st_w <= is_sc ? {48'd0, f32_to_half(payload[31:0])} : payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) st_valid <= 1'b0;
    else if (in_ready) st_valid <= acc && (is_w || is_sc);
  end
endmodule

FILE: rtl/i4dq_queue.sv
`timescale 1ns / 1ps
module i4dq_queue
  import i4dq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);
  job_t       ent [2];
  logic [1:0] cnt;
  logic       wp, rp;
  logic       wr, rd;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_job = ent[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) ent[wp] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end
endmodule

FILE: rtl/i4dq_back.sv
`timescale 1ns / 1ps
module i4dq_back
  import i4dq_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        j_valid,
  output logic        j_ready,
  input  job_t        j_job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic [9:0]  column,
  output logic        last
);
  localparam int AW = $clog2(COLUMNS);

  logic [15:0] scale_mem [COLUMNS];
  // Stage A: scale read and nibble pick. Stage B: product and rounding.
  logic        busy;
  logic [3:0]  k;
  logic        a_valid, b_valid;
  logic [15:0] a_h;
  logic signed [4:0] a_d;
  logic [9:0]  a_col, b_col;
  logic        a_last, b_last;
  logic [15:0] b_p;
  logic        adv_o, adv_b, adv_a;
  logic [3:0]  w, z;
  logic [9:0]  col_now;
  logic        pop;
  logic        sc_pop;

  assign adv_o = !out_valid || out_ready;
  assign adv_b = !b_valid || adv_o;
  assign adv_a = busy && adv_b;
  assign w = j_job.wword[4*k +: 4];
  assign z = j_job.zword[4*k +: 4] + 4'd1;
  assign col_now = 10'({j_job.slot, k});

  // A scale load at the queue head is written and popped in the same cycle.
  assign sc_pop = j_valid && j_job.scale_ld;

  always_ff @(posedge clk) begin
    if (sc_pop) scale_mem[AW'(j_job.slot)] <= j_job.wword[15:0];
    if (adv_a) begin
      a_h <= scale_mem[AW'({j_job.slot, k})];
      a_d <= $signed({1'b0, w}) - $signed({1'b0, z});
      a_col <= col_now;
      a_last <= k == 4'd15;
    end
  end

  // The job stays at the queue head until its sixteenth nibble is issued.
  assign busy = j_valid && !j_job.scale_ld;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= 4'd0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) k <= k + 4'd1;
      if (adv_b) a_valid <= adv_a;
      if (adv_b) b_valid <= a_valid;
      if (adv_o) out_valid <= b_valid;
    end
  end

  // Handshake with the queue: pop when nibble fifteen is issued, or when a scale load is at the head.
  assign pop = adv_a && k == 4'd15;
  assign j_ready = pop || sc_pop;

  function automatic logic [15:0] mul_half(input logic signed [4:0] d, input logic [15:0] h);
    logic        ds, s;
    logic [3:0]  ad;
    logic [4:0]  he;
    logic [10:0] m;
    logic [14:0] mag;
    logic [15:0] r;
    int          msb, scl, sh, ex;
    logic [14:0] q, rem, hlf;
    logic [15:0] qq;
    ds = d < 0;
    ad = 4'(ds ? -d : d);
    he = h[14:10];
    s = h[15] ^ ds;
    msb = 0;
    r = 16'd0;
    if (he == 5'h1F) begin
      if (h[9:0] != 10'd0) r = h | 16'h0200;
      else if (ad == 4'd0) r = 16'h7E00;
      else r = {s, 15'h7C00};
    end else begin
      m = (he != 5'd0) ? {1'b1, h[9:0]} : {1'b0, h[9:0]};
      mag = m * ad;
      ex = (he != 5'd0) ? int'(he) - 25 : -24;
      if (mag == 15'd0) r = {s, 15'd0};
      else begin
        for (int i = 0; i < 15; i++) if (mag[i]) msb = i;
        scl = msb + ex - 10;
        if (scl < -24) scl = -24;
        sh = scl - ex;
        if (sh <= 0) begin
          qq = 16'(mag);
        end else begin
          q = mag >> sh;
          rem = mag & ((15'd1 << sh) - 15'd1);
          hlf = 15'd1 << (sh - 1);
          qq = {1'b0, q} + 16'((rem > hlf) || (rem == hlf && q[0]));
        end
        if (qq >= 16'd2048) begin
          qq = qq >> 1;
          scl = scl + 1;
        end
        if (qq < 16'd1024) r = {s, qq[14:0]};
        else if (scl + 25 >= 31) r = {s, 15'h7C00};
        else r = {s, 5'(scl + 25), qq[9:0]};
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (adv_b) begin
      b_p <= mul_half(a_d, a_h);
      b_col <= a_col;
      b_last <= a_last;
    end
    if (adv_o) begin
      value <= half_to_f32(b_p);
      column <= b_col;
      last <= b_last;
    end
  end
endmodule

FILE: rtl/i4dq_checker.sv
`timescale 1ns / 1ps
`include "int4_group_dequantizer_assert.svh"
module i4dq_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  `ASSERT_CLK(out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `ASSERT_CLK(last_col, clk, rst, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[35:32] == 4'hF)
  `ASSERT_CLK(pad_zero, clk, rst, m_axis_tdata[47:42] == 6'd0 || !m_axis_tvalid)
  `ASSERT_RST(rst_idle, clk, rst |=> !m_axis_tvalid)
endmodule

bind int4_group_dequantizer i4dq_checker u_chk (.*);

FILE: sim/tb_int4_group_dequantizer.sv
`timescale 1ns / 1ps
module tb_int4_group_dequantizer;
  import i4dq_pkg::*;

  localparam int NCHUNK = 64;
  localparam int NCOL = 1024;
  localparam int LIMIT = 400000;
  localparam int RANDOM_ITEMS = 380;

  typedef struct {
    logic [31:0] value;
    logic [9:0]  column;
    logic        last;
  } dq_result_t;

  typedef struct {
    cmd_t        cmd;
    logic [9:0]  slot;
    int          span;
    logic [63:0] payload;
    bit          typed;
    logic [31:0] value;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  int4_group_dequantizer u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #4 clk = ~clk;

  logic [63:0] zero_words[NCHUNK];
  logic [15:0] half_scales[NCOL];
  bit          zero_loaded[NCHUNK];
  bit          scale_loaded[NCOL];
  dq_result_t  pending[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          weight_items = 0;
  int          load_items = 0;
  int          ignored_items = 0;
  int          results_seen = 0;
  int          burst_left = 0;

  // Rounds sign * mag * 2^ex to half precision, nearest even.
  function automatic logic [15:0] round_to_half(bit sign, longint unsigned mag, int ex);
    int msb;
    int sc;
    int sh;
    longint unsigned q;
    longint unsigned rem;
    longint unsigned hlf;
    msb = 0;
    if (mag == 0) return {sign, 15'd0};
    while (msb < 63 && (mag >> (msb + 1)) != 0) msb++;
    sc = msb + ex - 10;
    if (sc < -24) sc = -24;
    sh = sc - ex;
    if (sh <= 0) begin
      q = mag << (-sh);
    end else if (sh >= 64) begin
      q = 0;
    end else begin
      rem = mag & ((64'd1 << sh) - 64'd1);
      hlf = 64'd1 << (sh - 1);
      q = mag >> sh;
      if (rem > hlf || (rem == hlf && q[0])) q++;
    end
    if (q >= 2048) begin
      q = q >> 1;
      sc++;
    end
    if (q < 1024) return {sign, 5'd0, q[9:0]};
    if (sc + 25 >= 31) return {sign, 15'h7C00};
    return {sign, 5'(sc + 25), q[9:0]};
  endfunction

  function automatic logic [15:0] single_to_half(logic [31:0] b);
    if (b[30:23] == 8'hFF) begin
      if (b[22:0] == 0) return {b[31], 15'h7C00};
      return {b[31], 15'h7E00} | {6'd0, b[22:13]};
    end
    if (b[30:23] == 0) return round_to_half(b[31], {41'd0, b[22:0]}, -149);
    return round_to_half(b[31], {40'd0, 1'b1, b[22:0]}, int'(b[30:23]) - 150);
  endfunction

  function automatic logic [31:0] half_to_single(logic [15:0] h);
    logic [7:0] ee;
    logic [10:0] f;
    f = {1'b0, h[9:0]};
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    if (h[14:10] != 0) return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
    if (f == 0) return {h[15], 31'd0};
    ee = 8'd113;
    while (!f[10]) begin
      f = f << 1;
      ee--;
    end
    return {h[15], ee, f[9:0], 13'd0};
  endfunction

  // Product of a signed difference in -15..15 and a half scale, one half rounding.
  function automatic logic [15:0] scaled_diff(int d, logic [15:0] h);
    bit ds;
    longint unsigned ad;
    ds = d < 0;
    ad = d < 0 ? -d : d;
    if (h[14:10] == 5'h1F) begin
      if (h[9:0] != 0) return h | 16'h0200;
      if (ad == 0) return 16'h7E00;
      return {h[15] ^ ds, 15'h7C00};
    end
    if (h[14:10] != 0)
      return round_to_half(h[15] ^ ds, {53'd0, 1'b1, h[9:0]} * ad, int'(h[14:10]) - 25);
    return round_to_half(h[15] ^ ds, {54'd0, h[9:0]} * ad, -24);
  endfunction

  // Updates the stores or queues the sixteen expected weights of one item.
  task automatic absorb_item(cmd_t cmd, logic [9:0] slot, logic [63:0] payload,
                             bit typed, logic [31:0] typed_value);
    dq_result_t r;
    int w;
    int z;
    case (cmd)
      CMD_ZERO: begin
        if (slot < NCHUNK) begin
          zero_words[slot] = payload;
          zero_loaded[slot] = 1'b1;
          load_items++;
        end else begin
          ignored_items++;
        end
      end
      CMD_SCALE: begin
        half_scales[slot] = single_to_half(payload[31:0]);
        scale_loaded[slot] = 1'b1;
        load_items++;
      end
      CMD_WEIGHT: begin
        if (slot < NCHUNK) begin
          weight_items++;
          for (int k = 0; k < 16; k++) begin
            w = int'(payload[4*k +: 4]);
            z = int'(4'(zero_words[slot][4*k +: 4] + 4'd1));
            r.column = 10'(slot * 16 + k);
            r.last = (k == 15);
            r.value = typed ? typed_value :
                      half_to_single(scaled_diff(w - z, half_scales[r.column]));
            pending.push_back(r);
          end
        end else begin
          ignored_items++;
        end
      end
      default: ignored_items++;
    endcase
  endtask

  // The sender runs in bursts; between bursts it may drop valid for a random gap.
  task automatic send_item(cmd_t cmd, logic [9:0] slot, logic [63:0] payload,
                           bit typed = 1'b0, logic [31:0] typed_value = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {6'd0, payload, slot};
    do @(posedge clk); while (!s_axis_tready);
    absorb_item(cmd, slot, payload, typed, typed_value);
  endtask

  function automatic logic [31:0] pick_scale();
    logic [31:0] b;
    b = $urandom;
    case ($urandom_range(0, 7))
      0: ;
      1: b[30:23] = 8'($urandom_range(103, 142));
      2: b[30:23] = 8'($urandom_range(141, 143));
      3: b[30:23] = 8'($urandom_range(96, 113));
      4: b[30:0] = 31'h7F800000;
      5: begin
        b[30:23] = 8'hFF;
        if (b[22:0] == 0) b[22] = 1'b1;
      end
      6: b[30:23] = 8'd0;
      default: begin
        b[30:23] = 8'($urandom_range(110, 130));
        b[12:0] = 13'd0;
      end
    endcase
    return b;
  endfunction

  // Stalls of the result side change character from phase to phase: none, random, periodic, then frequent random ones.
  always @(posedge clk) begin
    case ((cycles / 128) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 9) < 7);
      2: m_axis_tready <= ((cycles % 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    dq_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: value %h column %0d last %b",
                   m_axis_tdata[31:0], m_axis_tdata[41:32], m_axis_tlast);
      end else begin
        e = pending.pop_front();
        if (m_axis_tdata[31:0] !== e.value || m_axis_tdata[41:32] !== e.column ||
            m_axis_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h column %0d last %b, got %h %0d %b",
                     e.value, e.column, e.last,
                     m_axis_tdata[31:0], m_axis_tdata[41:32], m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout with %0d results outstanding", pending.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  stim_row_t rows[20];

  initial begin
    int sent;
    int c;
    int n;
    rows[0]  = '{CMD_ZERO, 10'd0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0};
    rows[1]  = '{CMD_SCALE, 10'd0, 16, 64'h3F80_0000, 1'b0, 32'h0};
    rows[2]  = '{CMD_WEIGHT, 10'd0, 1, 64'h0, 1'b1, 32'h0000_0000};
    rows[3]  = '{CMD_WEIGHT, 10'd0, 1, 64'h1111_1111_1111_1111, 1'b1, 32'h3F80_0000};
    rows[4]  = '{CMD_WEIGHT, 10'd0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h4170_0000};
    rows[5]  = '{CMD_ZERO, 10'd0, 1, 64'h0, 1'b0, 32'h0};
    rows[6]  = '{CMD_WEIGHT, 10'd0, 1, 64'h0, 1'b1, 32'hBF80_0000};
    rows[7]  = '{CMD_SCALE, 10'd0, 16, 64'h7F80_0000, 1'b0, 32'h0};
    rows[8]  = '{CMD_WEIGHT, 10'd0, 1, 64'h1111_1111_1111_1111, 1'b1, 32'h7FC0_0000};
    rows[9]  = '{CMD_WEIGHT, 10'd0, 1, 64'h0F2E_4D6C_8BAA_C9E7, 1'b0, 32'h0};
    rows[10] = '{CMD_SCALE, 10'd0, 16, 64'hFFFF_FFFF_7FA0_0000, 1'b0, 32'h0};
    rows[11] = '{CMD_WEIGHT, 10'd0, 1, 64'h0123_4567_89AB_CDEF, 1'b0, 32'h0};
    rows[12] = '{CMD_SCALE, 10'd0, 16, 64'h501502F9, 1'b0, 32'h0};
    rows[13] = '{CMD_WEIGHT, 10'd0, 1, 64'hFEDC_BA98_7654_3210, 1'b0, 32'h0};
    rows[14] = '{CMD_SCALE, 10'd0, 16, 64'h3380_0000, 1'b0, 32'h0};
    rows[15] = '{CMD_WEIGHT, 10'd0, 1, 64'hFFFF_FFFF_0000_0000, 1'b0, 32'h0};
    rows[16] = '{CMD_SCALE, 10'd0, 16, 64'h8000_0001, 1'b0, 32'h0};
    rows[17] = '{CMD_WEIGHT, 10'd0, 1, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 32'h0};
    rows[18] = '{CMD_SCALE, 10'd0, 16, 64'h477F_E000, 1'b0, 32'h0};
    rows[19] = '{CMD_WEIGHT, 10'd0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i])
      for (int j = 0; j < rows[i].span; j++)
        send_item(rows[i].cmd, rows[i].slot + 10'(j), rows[i].payload,
                  rows[i].typed, rows[i].value);
    // Items the block must drop without a result.
    send_item(CMD_NONE, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_ZERO, 10'd100, 64'h0);
    send_item(CMD_WEIGHT, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF);

    // Mostly well-formed group reloads followed by weights, with some noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: send_item(CMD_NONE, 10'($urandom), {$urandom, $urandom});
          1: send_item(CMD_ZERO, 10'($urandom_range(NCHUNK, NCOL - 1)), {$urandom, $urandom});
          default: send_item(CMD_WEIGHT, 10'($urandom_range(NCHUNK, NCOL - 1)),
                             {$urandom, $urandom});
        endcase
        sent++;
      end else begin
        c = $urandom_range(0, NCHUNK - 1);
        if (!zero_loaded[c] || $urandom_range(0, 1) == 0) begin
          send_item(CMD_ZERO, 10'(c), {$urandom, $urandom});
          sent++;
        end
        for (int k = 0; k < 16; k++)
          if (!scale_loaded[c * 16 + k] || $urandom_range(0, 1) == 0) begin
            send_item(CMD_SCALE, 10'(c * 16 + k), {$urandom, pick_scale()});
            sent++;
          end
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_item(CMD_WEIGHT, 10'(c), {$urandom, $urandom});
          sent++;
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d weight items, %0d store loads and %0d dropped items sent;",
             weight_items, load_items, ignored_items);
    $display("%0d dequantized weights compared, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: int4_group_dequantizer.f
+incdir+rtl
rtl/i4dq_pkg.sv
rtl/i4dq_front.sv
rtl/i4dq_queue.sv
rtl/i4dq_back.sv
rtl/int4_group_dequantizer.sv
rtl/i4dq_checker.sv
sim/tb_int4_group_dequantizer.sv
